// ----- design/eiss_pkg.sv -----
`default_nettype none
package eiss_pkg;

  localparam int unsigned HOLE_COUNT_DEF = 32;

  localparam logic [31:0] SPEED_NUM = 32'd60000000;
  // quotient bits needed to cover the whole numerator
  localparam int unsigned NUM_W     = 26;
  localparam logic [15:0] SPEED_SAT = 16'hFFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ----- design/eiss_divider.sv -----
`default_nettype none
module eiss_divider import eiss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] divisor_i,
  output logic [15:0]      quotient_o,
  output div_stat_t        stat_o
);

  localparam int unsigned BIT_W = $clog2(NUM_W);

  logic [31:0]      div_q;
  logic [31:0]      rem_q;
  logic [15:0]      quo_q;
  logic [BIT_W-1:0] bit_q;
  logic             busy_q;
  logic             done_q;

  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        take;

  // restoring step, one numerator bit per cycle
  assign rem_sh = {rem_q, SPEED_NUM[bit_q]};
  assign diff   = rem_sh - {1'b0, div_q};
  assign take   = (rem_sh >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        bit_q  <= BIT_W'(NUM_W - 1);
      end else if (busy_q) begin
        if (bit_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
          bit_q  <= bit_q - 1'b1;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? diff[31:0] : rem_sh[31:0];
      // older quotient bits fall off the top: truncation to 16 bits
      quo_q <= {quo_q[14:0], take};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

// ----- design/encoder_index_sync_speed_unit.sv -----
`default_nettype none
// Encoder index tracking and rotation speed.
// Input channel: in_valid_i / in_stall_o with capture_time_i, a 16-bit timer
// capture taken at each encoder edge. Output channel: out_valid_o /
// out_stall_i with one result per request: hole index, speed, update flag,
// sync flag and a capture error flag.
// A request is taken only while the sequencer is idle; it sets in_stall_o
// for the rest of the work. An ordinary edge (or an equal capture, flagged as
// an error) goes straight to ST_DONE, which loads its result into the output
// register once it is free. The edge that closes a revolution takes longer:
// unsynced, a serial minimum search reads the period memory one entry per
// cycle; synced, the bit-serial divider computes 60000000 / accumulator.
// Reset clears the index, sync flag, accumulator, speed and last capture; the
// period memory is not cleared, since a full revolution writes every entry
// before any is read.
// A result waits in the output register while out_stall_i is high; a new
// request may be taken meanwhile, and its result waits for the register.
module encoder_index_sync_speed_unit import eiss_pkg::*; #(
  parameter int unsigned HOLE_COUNT = HOLE_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] capture_time_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       hole_index_o,
  output logic [15:0]      speed_rpm_o,
  output logic             speed_updated_o,
  output logic             in_sync_o,
  output logic             capture_error_o
);

  localparam int unsigned IDX_W = $clog2(HOLE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOLE_COUNT - 1);
  localparam logic [IDX_W-1:0] P1_IDX   = IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [15:0]      last_q;
  logic [IDX_W-1:0] ev_q;
  logic             sync_q;
  logic [31:0]      acc_q;
  logic [15:0]      speed_q;
  logic             upd_q;
  logic             err_q;
  logic             acc_zero_q;

  logic [IDX_W-1:0] cnt_q;
  logic             issue_q;
  logic [IDX_W-1:0] tag_q;
  logic             tag_vld_q;
  logic [15:0]      best_q;
  logic [IDX_W-1:0] pos_q;
  logic [15:0]      p0_q;
  logic [15:0]      p1_q;
  logic             chk_rdy_q;

  logic             out_valid_q;
  logic [7:0]       out_idx_q;
  logic [15:0]      out_speed_q;
  logic             out_upd_q;
  logic             out_sync_q;
  logic             out_err_q;

  logic [15:0] mem [HOLE_COUNT];
  logic [15:0] rd_data_q;

  logic        accept;
  logic        equal;
  logic [15:0] period;
  logic [31:0] acc_sum;
  logic        wrap;
  logic        wr_en;
  logic        rd_en;
  logic        div_start;
  logic [15:0] quotient;
  div_stat_t   div_stat;
  logic        better;
  logic [IDX_W-1:0] pos_new;
  logic [IDX_W-1:0] align_idx;
  logic [18:0] lhs;
  logic [18:0] rhs;
  logic        out_free;

  assign accept    = in_valid_i && !in_stall_o;
  assign equal     = (capture_time_i == last_q);
  assign period    = capture_time_i - last_q;
  assign acc_sum   = acc_q + {16'd0, period};
  assign wrap      = (ev_q == LAST_IDX);
  assign wr_en     = accept && !equal;
  assign div_start = wr_en && wrap && sync_q;
  assign rd_en     = issue_q && (state_q == ST_SCAN || state_q == ST_CHECK);

  // first lowest period wins the marker search
  assign better    = (tag_q == '0) || (rd_data_q < best_q);
  assign pos_new   = better ? tag_q : pos_q;
  assign align_idx = (pos_new == '0) ? '0 : IDX_W'(HOLE_COUNT - int'(pos_new));

  assign lhs = {3'd0, p0_q} + {1'b0, p0_q, 2'd0};
  assign rhs = {2'd0, p1_q, 1'b0};

  assign out_free = !out_valid_q || !out_stall_i;

  eiss_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (acc_sum),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ev_q] <= period;
    end
    if (rd_en) begin
      rd_data_q <= mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      ev_q        <= '0;
      sync_q      <= 1'b0;
      acc_q       <= '0;
      speed_q     <= '0;
      upd_q       <= 1'b0;
      err_q       <= 1'b0;
      acc_zero_q  <= 1'b0;
      cnt_q       <= '0;
      issue_q     <= 1'b0;
      tag_q       <= '0;
      tag_vld_q   <= 1'b0;
      best_q      <= '0;
      pos_q       <= '0;
      p0_q        <= '0;
      p1_q        <= '0;
      chk_rdy_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_speed_q <= '0;
      out_upd_q   <= 1'b0;
      out_sync_q  <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      // in ST_DONE the output register is reloaded instead
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      tag_q     <= cnt_q;
      tag_vld_q <= rd_en;

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            upd_q <= 1'b0;
            err_q <= equal;
            cnt_q <= '0;
            if (equal) begin
              issue_q <= 1'b0;
              state_q <= ST_DONE;
            end else begin
              last_q <= capture_time_i;
              if (!wrap) begin
                acc_q   <= acc_sum;
                ev_q    <= ev_q + 1'b1;
                issue_q <= 1'b0;
                state_q <= ST_DONE;
              end else if (!sync_q) begin
                acc_q   <= acc_sum;
                issue_q <= 1'b1;
                state_q <= ST_SCAN;
              end else begin
                acc_q      <= '0;
                acc_zero_q <= (acc_sum == '0);
                issue_q    <= 1'b1;
                chk_rdy_q  <= 1'b0;
                state_q    <= ST_CHECK;
              end
            end
          end
        end

        ST_SCAN: begin
          if (issue_q) begin
            if (cnt_q == LAST_IDX) begin
              issue_q <= 1'b0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          if (tag_vld_q) begin
            if (better) begin
              best_q <= rd_data_q;
            end
            pos_q <= pos_new;
            if (tag_q == LAST_IDX) begin
              ev_q    <= align_idx;
              sync_q  <= 1'b1;
              state_q <= ST_DONE;
            end
          end
        end

        ST_CHECK: begin
          if (issue_q) begin
            if (cnt_q == P1_IDX) begin
              issue_q <= 1'b0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          if (tag_vld_q) begin
            if (tag_q == '0) begin
              p0_q <= rd_data_q;
            end else begin
              p1_q      <= rd_data_q;
              chk_rdy_q <= 1'b1;
            end
          end
          if (chk_rdy_q && !div_stat.busy) begin
            sync_q  <= (lhs < rhs);
            speed_q <= acc_zero_q ? SPEED_SAT : quotient;
            upd_q   <= 1'b1;
            ev_q    <= '0;
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= 8'(ev_q);
            out_speed_q <= speed_q;
            out_upd_q   <= upd_q;
            out_sync_q  <= sync_q;
            out_err_q   <= err_q;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hole_index_o    = out_idx_q;
  assign speed_rpm_o     = out_speed_q;
  assign speed_updated_o = out_upd_q;
  assign in_sync_o       = out_sync_q;
  assign capture_error_o = out_err_q;

  a_index_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q <= LAST_IDX)
    else $error("hole index out of range");

  a_err_keeps_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && equal |=> $stable(last_q) && $stable(acc_q) && $stable(ev_q))
    else $error("equal capture changed state");

  a_upd_no_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && speed_updated_o |-> !capture_error_o && out_idx_q == 8'd0)
    else $error("speed update with error or nonzero index");

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy && state_q == ST_IDLE)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire

// ----- bench/eiss_checker.sv -----
`timescale 1ns / 1ps
module eiss_checker import eiss_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_o,
  input  wire logic [15:0] capture_time_i,
  input  wire logic        out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic [7:0]  hole_index_o,
  input  wire logic [15:0] speed_rpm_o,
  input  wire logic        speed_updated_o,
  input  wire logic        in_sync_o,
  input  wire logic        capture_error_o,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int unsigned HOLES = HOLE_COUNT_DEF;
  localparam logic [31:0] RPM_NUMERATOR = 32'd60000000;

  typedef struct packed {
    logic [7:0]  hole_index;
    logic [15:0] speed_rpm;
    logic        speed_updated;
    logic        in_sync;
    logic        capture_error;
  } encoder_reading_t;

  encoder_reading_t readings_q[$];

  logic [15:0] last_cap;
  logic [15:0] hole_period [HOLES];
  logic [7:0]  hole_idx;
  logic        synced;
  logic [31:0] rev_accum;
  logic [15:0] rpm_now;
  int          failures;

  // track one encoder edge and queue the reading it should produce
  task automatic track_encoder_edge(input logic [15:0] now);
    encoder_reading_t r;
    logic [15:0]      period;
    int unsigned      nxt;
    int unsigned      pos;
    logic [31:0]      lhs;
    logic [31:0]      rhs;
    logic [31:0]      quot;
    r.speed_updated = 1'b0;
    r.capture_error = 1'b0;
    if (now == last_cap) begin
      r.capture_error = 1'b1;
    end else begin
      period    = now - last_cap;
      last_cap  = now;
      rev_accum = rev_accum + {16'd0, period};
      hole_period[hole_idx] = period;
      nxt = hole_idx + 1;
      if (nxt >= HOLES) begin
        if (!synced) begin
          // shortest period marks the reference hole, lowest index on a tie
          pos = 0;
          for (int k = 1; k < HOLES; k++) begin
            if (hole_period[k] < hole_period[pos]) pos = k;
          end
          nxt    = HOLES - pos;
          synced = 1'b1;
        end else begin
          lhs    = 32'(hole_period[0]) * 32'd5;
          rhs    = 32'(hole_period[1]) * 32'd2;
          synced = (lhs < rhs);
          if (rev_accum == 32'd0) begin
            rpm_now = 16'hFFFF;
          end else begin
            quot    = RPM_NUMERATOR / rev_accum;
            rpm_now = quot[15:0];
          end
          rev_accum       = 32'd0;
          r.speed_updated = 1'b1;
        end
        nxt = nxt % HOLES;
      end
      hole_idx = 8'(nxt);
    end
    r.hole_index = hole_idx;
    r.speed_rpm  = rpm_now;
    r.in_sync    = synced;
    readings_q.push_back(r);
  endtask

  task automatic check_reading();
    encoder_reading_t e;
    if (readings_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: idx %0d rpm %0d upd %0b sync %0b err %0b",
                 hole_index_o, speed_rpm_o, speed_updated_o, in_sync_o, capture_error_o);
    end else begin
      e = readings_q.pop_front();
      if (e.hole_index !== hole_index_o || e.speed_rpm !== speed_rpm_o ||
          e.speed_updated !== speed_updated_o || e.in_sync !== in_sync_o ||
          e.capture_error !== capture_error_o) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: idx %0d/%0d rpm %0d/%0d upd %0b/%0b sync %0b/%0b err %0b/%0b",
                   e.hole_index, hole_index_o, e.speed_rpm, speed_rpm_o,
                   e.speed_updated, speed_updated_o, e.in_sync, in_sync_o,
                   e.capture_error, capture_error_o);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      readings_q.delete();
      last_cap  = 16'd0;
      hole_idx  = 8'd0;
      synced    = 1'b0;
      rev_accum = 32'd0;
      rpm_now   = 16'd0;
      failures  = 0;
      for (int k = 0; k < HOLES; k++) hole_period[k] = 16'd0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_reading();
      if (in_valid_i && !in_stall_o) track_encoder_edge(capture_time_i);
      fail_count_o <= failures;
      pending_o    <= readings_q.size();
    end
  end

endmodule

// ----- bench/encoder_index_sync_speed_unit_tb.sv -----
`timescale 1ns / 1ps
module encoder_index_sync_speed_unit_tb import eiss_pkg::*;;

  localparam int unsigned HOLES = HOLE_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 460;
  localparam logic [15:0] DIRECTED_CAPS [20] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h7FFF,
    16'hFFFE, 16'hFFFE, 16'h0005, 16'h5555, 16'hAAAA, 16'hAAAB, 16'hAAAC,
    16'hAAAC, 16'hFF00, 16'h00FF, 16'h0100, 16'h0101, 16'h0102
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] capture_time_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  hole_index_o;
  logic [15:0] speed_rpm_o;
  logic        speed_updated_o;
  logic        in_sync_o;
  logic        capture_error_o;
  int          fail_count;
  int          pending;

  int          idle_pct;
  int          stall_pct;
  int          idle_cycles;
  int          marker_slot;
  int          edge_phase;
  logic [15:0] cap_now;

  encoder_index_sync_speed_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .capture_time_i,
    .out_valid_o, .out_stall_i, .hole_index_o, .speed_rpm_o,
    .speed_updated_o, .in_sync_o, .capture_error_o
  );

  eiss_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .capture_time_i,
    .out_valid_o, .out_stall_i, .hole_index_o, .speed_rpm_o,
    .speed_updated_o, .in_sync_o, .capture_error_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_capture(input logic [15:0] c);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    capture_time_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // revolutions of roughly even holes, mostly with one short marker gap, plus random captures
  task automatic run_random(input int n_items);
    int sent;
    int mode;
    int base;
    int mark;
    int per;
    int h;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) base = $urandom_range(2000, 65535);
      else if ($urandom_range(0, 3) == 0) base = $urandom_range(2, 60);
      else base = $urandom_range(100, 2000);
      if (mode < 65) mark = base * $urandom_range(5, 35) / 100;
      else if (mode < 78) mark = base;
      else mark = base * $urandom_range(40, 90) / 100;
      if (mark < 1) mark = 1;
      if ($urandom_range(0, 3) == 0) marker_slot = $urandom_range(0, HOLES - 1);
      h = 0;
      while (h < HOLES && sent < n_items) begin
        if (mode >= 92) begin
          cap_now = 16'($urandom_range(0, 65535));
          h++;
        end else if ($urandom_range(0, 24) != 0) begin
          if (edge_phase == marker_slot) per = mark;
          else if (mode >= 65 && mode < 78) per = base;
          else per = base + $urandom_range(0, base / 16);
          if (per > 65535) per = 65535;
          cap_now    = cap_now + 16'(per);
          edge_phase = (edge_phase + 1) % HOLES;
          h++;
        end
        // otherwise the same capture goes again and must be flagged
        send_capture(cap_now);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    capture_time_i = 16'd0;
    idle_pct       = 0;
    stall_pct      = 0;
    marker_slot    = 0;
    edge_phase     = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < 20; i++) send_capture(DIRECTED_CAPS[i]);
    cap_now = DIRECTED_CAPS[19];
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    idle_pct = 78;
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    idle_pct  = 0;
    stall_pct = 78;
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    idle_pct  = 23;
    stall_pct = 23;
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
